/* hw/rtl/format_spec_parser_unit_defines.svh */
// Assertion macros shared by the format spec parser RTL files.
`ifndef FORMAT_SPEC_PARSER_UNIT_DEFINES_SVH
`define FORMAT_SPEC_PARSER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// Check a property at every clock edge outside of reset.
`define FSP_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check a property at every clock edge, reset included.
`define FSP_ASSERT_NR(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define FSP_ASSERT(label, clk, rst_n, prop, msg)
`define FSP_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

/* hw/rtl/fsp_pkg.sv */
// Shared types, character codes and specifier codes of the format spec parser.
`timescale 1ns / 1ps
package fsp_pkg;

    // Default saturation width of the width and precision counters
    localparam int COUNT_BITS_DEF = 31;

    // Character codes
    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_LOW_C   = 8'h63;
    localparam logic [7:0] CH_LOW_S   = 8'h73;
    localparam logic [7:0] CH_LOW_P   = 8'h70;
    localparam logic [7:0] CH_LOW_D   = 8'h64;
    localparam logic [7:0] CH_LOW_I   = 8'h69;
    localparam logic [7:0] CH_LOW_U   = 8'h75;
    localparam logic [7:0] CH_LOW_X   = 8'h78;
    localparam logic [7:0] CH_UP_X    = 8'h58;
    localparam logic [7:0] CH_PERCENT = 8'h25;

    // Specifier codes
    localparam logic [3:0] SPEC_NONE    = 4'd0;
    localparam logic [3:0] SPEC_CHAR    = 4'd1;
    localparam logic [3:0] SPEC_STR     = 4'd2;
    localparam logic [3:0] SPEC_PTR     = 4'd3;
    localparam logic [3:0] SPEC_DEC     = 4'd4;
    localparam logic [3:0] SPEC_INT     = 4'd5;
    localparam logic [3:0] SPEC_UNS     = 4'd6;
    localparam logic [3:0] SPEC_HEX_LO  = 4'd7;
    localparam logic [3:0] SPEC_HEX_UP  = 4'd8;
    localparam logic [3:0] SPEC_PERCENT = 4'd9;

    // Classification of one incoming character
    typedef struct packed {
        logic       is_minus;
        logic       is_zero;
        logic       is_space;
        logic       is_plus;
        logic       is_hash;
        logic       is_star;
        logic       is_dot;
        logic       is_digit;
        logic [3:0] digit;
        logic [3:0] spec_code;
    } t_char_class;

    // Flags collected over one spec
    typedef struct packed {
        logic left;
        logic zero;
        logic space;
        logic plus;
        logic alt;
        logic prec;
    } t_flags;

    // One finished spec
    typedef struct packed {
        logic        left_justify;
        logic        zero_pad;
        logic        space_sign;
        logic        plus_sign;
        logic        alt_form;
        logic        precision_on;
        logic [30:0] field_width;
        logic [30:0] prec_value;
        logic [3:0]  spec_code;
        logic        char_consumed;
    } t_result;

    // Map a conversion character to its specifier code; NUL is never one
    function automatic logic [3:0] spec_lookup(input logic [7:0] c);
        logic [3:0] code;
        case (c)
            CH_LOW_C:   code = SPEC_CHAR;
            CH_LOW_S:   code = SPEC_STR;
            CH_LOW_P:   code = SPEC_PTR;
            CH_LOW_D:   code = SPEC_DEC;
            CH_LOW_I:   code = SPEC_INT;
            CH_LOW_U:   code = SPEC_UNS;
            CH_LOW_X:   code = SPEC_HEX_LO;
            CH_UP_X:    code = SPEC_HEX_UP;
            CH_PERCENT: code = SPEC_PERCENT;
            CH_NUL:     code = SPEC_NONE;
            default:    code = SPEC_NONE;
        endcase
        return code;
    endfunction

endpackage

/* hw/rtl/format_spec_parser_unit.sv */
// Format spec parser top level: input register, parse stage, result register.
//
// Usage:
//   Feed the characters that follow a percent sign on the request channel
//   (i_valid, o_stall, i_char_code, i_star_value), one per cycle. i_star_value
//   is read only with a '*' character. A request is taken at a clock edge
//   with i_valid high and o_stall low.
//   One result leaves on o_valid / i_stall when a conversion character from
//   c s p d i u x X % ends the spec (char_consumed set), or when any other
//   character, NUL included, ends it unconsumed (spec_code 0). All other
//   characters give no result. The next character starts a new spec.
//   The request that ends the spec passes the input register and then the
//   result register, whose occupancy drives o_valid.
//   One request per cycle while o_stall is low; the parse step is a single
//   pass of compare logic and one multiply-by-ten add between the two registers.
//   While i_stall holds a waiting result, one more request is still taken, and
//   requests that give no result keep flowing; o_stall rises only when a
//   request that ends a spec finds the result register full and stalled.
//   Reset (i_rst_n low, synchronous) empties both registers and returns the
//   parser to the flags phase with all flags, width and precision cleared.
`timescale 1ns / 1ps
`include "format_spec_parser_unit_defines.svh"
module format_spec_parser_unit #(
    parameter int COUNT_BITS = fsp_pkg::COUNT_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [7:0]         i_char_code,
    input  logic signed [31:0] i_star_value,
    output logic               o_valid,
    input  logic               i_stall,
    output logic               o_left_justify,
    output logic               o_zero_pad,
    output logic               o_space_sign,
    output logic               o_plus_sign,
    output logic               o_alt_form,
    output logic               o_precision_on,
    output logic [30:0]        o_field_width,
    output logic [30:0]        o_prec_value,
    output logic [3:0]         o_spec_code,
    output logic               o_char_consumed
);
    import fsp_pkg::*;

    logic        r_in_valid;
    logic        n_in_valid;
    logic [7:0]  r_in_char;
    logic [31:0] r_in_star;
    logic        r_out_valid;
    logic        n_out_valid;
    t_result     r_out;
    t_char_class cls;
    t_result     res;
    logic        res_valid;
    logic        advance;
    logic        step;
    logic        in_take;
    logic        out_load;

    // Classify the registered character
    fsp_decode u_decode (
        .i_char (r_in_char),
        .o_cls  (cls)
    );

    // Run the parse step
    fsp_parse #(
        .COUNT_BITS (COUNT_BITS)
    ) u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_cls       (cls),
        .i_star      (r_in_star),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // Advance unless a result would land on a full, stalled result register
    assign advance  = !r_out_valid || !i_stall || !res_valid;
    assign step     = r_in_valid && advance;
    assign o_stall  = r_in_valid && !advance;
    assign in_take  = i_valid && !o_stall;
    assign out_load = step && res_valid;

    // Track input and result register occupancy
    always_comb begin
        n_in_valid  = in_take ? 1'b1 : (advance ? 1'b0 : r_in_valid);
        n_out_valid = out_load ? 1'b1 : (i_stall ? r_out_valid : 1'b0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // Capture the request payload
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_char <= i_char_code;
            r_in_star <= i_star_value;
        end
    end

    // Capture the result payload
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= res;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_left_justify  = r_out.left_justify;
    assign o_zero_pad      = r_out.zero_pad;
    assign o_space_sign    = r_out.space_sign;
    assign o_plus_sign     = r_out.plus_sign;
    assign o_alt_form      = r_out.alt_form;
    assign o_precision_on  = r_out.precision_on;
    assign o_field_width   = r_out.field_width;
    assign o_prec_value    = r_out.prec_value;
    assign o_spec_code     = r_out.spec_code;
    assign o_char_consumed = r_out.char_consumed;

    `FSP_ASSERT(a_stall_cause, i_clk, i_rst_n, o_stall |-> (r_out_valid && i_stall),
                "input stalled while the result register could take a result")
    `FSP_ASSERT(a_consumed_code, i_clk, i_rst_n,
                r_out_valid |-> (r_out.char_consumed == (r_out.spec_code != SPEC_NONE)),
                "consumed bit disagrees with spec code")
    `FSP_ASSERT_NR(a_reset_empty, i_clk,
                   $past(!i_rst_n) |-> (!r_out_valid && !r_in_valid),
                   "registers not empty after reset")

endmodule

/* hw/rtl/fsp_decode.sv */
// Character classifier: flags, star, dot, digits and specifier code.
`timescale 1ns / 1ps
module fsp_decode (
    input  logic [7:0]           i_char,
    output fsp_pkg::t_char_class o_cls
);
    import fsp_pkg::*;

    logic is_digit;

    // Flag a decimal digit; its value sits in the low nibble
    assign is_digit = (i_char >= CH_ZERO) && (i_char <= CH_NINE);

    // Compare against each special character and look up the specifier
    always_comb begin
        o_cls.is_minus  = (i_char == CH_MINUS);
        o_cls.is_zero   = (i_char == CH_ZERO);
        o_cls.is_space  = (i_char == CH_SPACE);
        o_cls.is_plus   = (i_char == CH_PLUS);
        o_cls.is_hash   = (i_char == CH_HASH);
        o_cls.is_star   = (i_char == CH_STAR);
        o_cls.is_dot    = (i_char == CH_DOT);
        o_cls.is_digit  = is_digit;
        o_cls.digit     = is_digit ? i_char[3:0] : 4'd0;
        o_cls.spec_code = spec_lookup(i_char);
    end

endmodule

/* hw/rtl/fsp_parse.sv */
// Spec state registers with next-state and result logic for one character.
`timescale 1ns / 1ps
`include "format_spec_parser_unit_defines.svh"
module fsp_parse #(
    parameter int COUNT_BITS = fsp_pkg::COUNT_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  fsp_pkg::t_char_class i_cls,
    input  logic [31:0]          i_star,
    output logic                 o_res_valid,
    output fsp_pkg::t_result     o_res
);
    import fsp_pkg::*;

    localparam int AccW = COUNT_BITS + 4;
    localparam logic [COUNT_BITS-1:0] CountMax = '1;

    typedef enum logic [5:0] {
        PH_FLAGS = 6'b000001,
        PH_WDIG  = 6'b000010,
        PH_WSTAR = 6'b000100,
        PH_DOT   = 6'b001000,
        PH_PDIG  = 6'b010000,
        PH_PSTAR = 6'b100000
    } t_phase;

    t_phase                r_phase;
    t_phase                n_phase;
    t_flags                r_flags;
    t_flags                n_flags;
    logic [COUNT_BITS-1:0] r_width;
    logic [COUNT_BITS-1:0] n_width;
    logic [COUNT_BITS-1:0] r_prec;
    logic [COUNT_BITS-1:0] n_prec;
    logic                  star_neg;
    logic [31:0]           star_mag;
    logic                  finish;

    // Multiply by ten and add a digit, clamp at the counter maximum
    function automatic logic [COUNT_BITS-1:0] sat_acc(input logic [COUNT_BITS-1:0] acc,
                                                      input logic [3:0] digit);
        logic [AccW-1:0] wide;
        logic [AccW-1:0] sum;
        wide = AccW'(acc);
        sum  = (wide << 3) + (wide << 1) + AccW'(digit);
        if (sum[AccW-1:COUNT_BITS] != '0) begin
            return CountMax;
        end
        return sum[COUNT_BITS-1:0];
    endfunction

    // Clamp a star magnitude at the counter maximum
    function automatic logic [COUNT_BITS-1:0] sat_val(input logic [31:0] mag);
        if ({1'b0, mag} > 33'(CountMax)) begin
            return CountMax;
        end
        return COUNT_BITS'(mag);
    endfunction

    // Take the magnitude of the star argument
    assign star_neg = i_star[31];
    assign star_mag = star_neg ? (32'd0 - i_star) : i_star;

    // Advance the phase for one character
    always_comb begin
        n_phase = r_phase;
        n_flags = r_flags;
        n_width = r_width;
        n_prec  = r_prec;
        finish  = 1'b0;
        case (r_phase)
            PH_FLAGS: begin
                if (i_cls.is_minus) begin
                    n_flags.left = 1'b1;
                end else if (i_cls.is_zero) begin
                    n_flags.zero = 1'b1;
                end else if (i_cls.is_space) begin
                    n_flags.space = 1'b1;
                end else if (i_cls.is_plus) begin
                    n_flags.plus = 1'b1;
                end else if (i_cls.is_hash) begin
                    n_flags.alt = 1'b1;
                end else if (i_cls.is_star) begin
                    n_flags.left = r_flags.left | star_neg;
                    n_width      = sat_val(star_mag);
                    n_phase      = PH_WSTAR;
                end else if (i_cls.is_digit) begin
                    n_width = sat_acc('0, i_cls.digit);
                    n_phase = PH_WDIG;
                end else if (i_cls.is_dot) begin
                    n_flags.prec = 1'b1;
                    n_phase      = PH_DOT;
                end else begin
                    finish = 1'b1;
                end
            end
            PH_WDIG: begin
                if (i_cls.is_digit) begin
                    n_width = sat_acc(r_width, i_cls.digit);
                end else if (i_cls.is_dot) begin
                    n_flags.prec = 1'b1;
                    n_phase      = PH_DOT;
                end else begin
                    finish = 1'b1;
                end
            end
            PH_WSTAR: begin
                if (i_cls.is_dot) begin
                    n_flags.prec = 1'b1;
                    n_phase      = PH_DOT;
                end else begin
                    finish = 1'b1;
                end
            end
            PH_DOT: begin
                if (i_cls.is_star) begin
                    // a negative star precision cancels the dot
                    if (star_neg) begin
                        n_flags.prec = 1'b0;
                    end else begin
                        n_prec = sat_val(star_mag);
                    end
                    n_phase = PH_PSTAR;
                end else if (i_cls.is_digit) begin
                    n_prec  = sat_acc('0, i_cls.digit);
                    n_phase = PH_PDIG;
                end else begin
                    finish = 1'b1;
                end
            end
            PH_PDIG: begin
                if (i_cls.is_digit) begin
                    n_prec = sat_acc(r_prec, i_cls.digit);
                end else begin
                    finish = 1'b1;
                end
            end
            PH_PSTAR: begin
                finish = 1'b1;
            end
            default: begin
                finish = 1'b1;
            end
        endcase
        // drop all spec state once the spec ends
        if (finish) begin
            n_phase = PH_FLAGS;
            n_flags = '0;
            n_width = '0;
            n_prec  = '0;
        end
    end

    // Build the result from the state the ending character saw
    always_comb begin
        o_res.left_justify  = r_flags.left;
        o_res.zero_pad      = r_flags.zero;
        o_res.space_sign    = r_flags.space;
        o_res.plus_sign     = r_flags.plus;
        o_res.alt_form      = r_flags.alt;
        o_res.precision_on  = r_flags.prec;
        o_res.field_width   = 31'(r_width);
        o_res.prec_value    = 31'(r_prec);
        o_res.spec_code     = i_cls.spec_code;
        o_res.char_consumed = (i_cls.spec_code != SPEC_NONE);
    end

    assign o_res_valid = finish;

    // Hold spec state between characters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_FLAGS;
            r_flags <= '0;
            r_width <= '0;
            r_prec  <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_flags <= n_flags;
            r_width <= n_width;
            r_prec  <= n_prec;
        end
    end

    `FSP_ASSERT(a_end_clears, i_clk, i_rst_n, (i_step && finish) |=> (r_phase == PH_FLAGS && r_flags == '0 && r_width == '0 && r_prec == '0), "spec state not cleared after a result")
    `FSP_ASSERT(a_no_prec_early, i_clk, i_rst_n, (r_phase == PH_FLAGS || r_phase == PH_WDIG || r_phase == PH_WSTAR) |-> (!r_flags.prec && r_prec == '0), "precision state set before the dot")

endmodule
